// File: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
// expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wvsl_pkg.sv
// types, constants and helpers for the windowed vote stepped level block
// no dependencies
package wvsl_pkg;

  localparam int WINDOW = 10;
  localparam int CNT_W = ($clog2(WINDOW + 1) > 4) ? $clog2(WINDOW + 1) : 4;

  localparam int LEVEL_W = 10;
  localparam int VOTE_W = 4;
  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;
  localparam int CAP_W = 8;

  localparam int IN_W = 40;
  localparam int OUT_W = 24;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [LEVEL_W-1:0] STEP_SIZE = 10'sd25;
  localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = 10'sd128;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -10'sd24;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 10'sd279;

  localparam logic [VOTE_W-1:0] THRESHOLD_RESET = 4'd6;
  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd1000;
  localparam logic [CAP_W-1:0] UPPER_CAP_RESET = 8'd253;
  localparam logic [CAP_W-1:0] LOWER_CAP_RESET = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_VOTE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_CAP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_CAP = 8'd3;

  typedef enum logic [1:0] {
    CHG_NONE = 2'd0,
    CHG_UP   = 2'd1,
    CHG_DOWN = 2'd2
  } chg_t;

  typedef struct packed {
    logic [VOTE_W-1:0]  vote_threshold;
    logic [HOLD_W-1:0]  holdoff_ms;
    logic [CAP_W-1:0]   upper_cap;
    logic [CAP_W-1:0]   lower_cap;
  } cfg_t;

  typedef struct packed {
    logic [WINDOW-1:0]         up_win;
    logic [WINDOW-1:0]         down_win;
    logic [TIME_W-1:0]         last_change;
    logic signed [LEVEL_W-1:0] level;
  } state_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [VOTE_W-1:0]         down_votes;
    logic [VOTE_W-1:0]         up_votes;
    chg_t                      change;
    logic signed [LEVEL_W-1:0] level;
  } res_t;

  function automatic logic [CNT_W-1:0] ones_in(input logic [WINDOW-1:0] w);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WINDOW; i++) begin
      n = n + CNT_W'(w[i]);
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/wvsl_step.sv
// one update of the vote windows and the stepped level
// depends on wvsl_pkg
module wvsl_step (
  input  wvsl_pkg::cfg_t                 cfg,
  input  wvsl_pkg::state_t               st,
  input  logic                           up_sample,
  input  logic                           down_sample,
  input  logic [wvsl_pkg::TIME_W-1:0]    now_ms,
  output wvsl_pkg::state_t               st_nxt,
  output wvsl_pkg::res_t                 res
);

  logic [wvsl_pkg::WINDOW-1:0] up_win;
  logic [wvsl_pkg::WINDOW-1:0] down_win;
  logic [wvsl_pkg::CNT_W-1:0]  up_cnt;
  logic [wvsl_pkg::CNT_W-1:0]  down_cnt;
  logic [wvsl_pkg::TIME_W-1:0] elapsed;
  logic                        hold_ok;
  logic                        up_go;
  logic                        down_go;
  logic signed [wvsl_pkg::LEVEL_W-1:0] upper_s;
  logic signed [wvsl_pkg::LEVEL_W-1:0] lower_s;

  always_comb begin
    up_win   = (st.up_win << 1) | wvsl_pkg::WINDOW'(up_sample);
    down_win = (st.down_win << 1) | wvsl_pkg::WINDOW'(down_sample);
    up_cnt   = wvsl_pkg::ones_in(up_win);
    down_cnt = wvsl_pkg::ones_in(down_win);
    elapsed  = now_ms - st.last_change;
    hold_ok  = elapsed > wvsl_pkg::TIME_W'(cfg.holdoff_ms);
    upper_s  = signed'(wvsl_pkg::LEVEL_W'(cfg.upper_cap));
    lower_s  = signed'(wvsl_pkg::LEVEL_W'(cfg.lower_cap));
    up_go    = (up_cnt >= wvsl_pkg::CNT_W'(cfg.vote_threshold)) && hold_ok &&
               (st.level < upper_s);
    down_go  = (down_cnt >= wvsl_pkg::CNT_W'(cfg.vote_threshold)) && hold_ok &&
               (st.level > lower_s);

    st_nxt.up_win      = up_win;
    st_nxt.down_win    = down_win;
    priority if (up_go) begin
      st_nxt.level       = st.level + wvsl_pkg::STEP_SIZE;
      st_nxt.last_change = now_ms;
      res.change         = wvsl_pkg::CHG_UP;
    end else if (down_go) begin
      st_nxt.level       = st.level - wvsl_pkg::STEP_SIZE;
      st_nxt.last_change = now_ms;
      res.change         = wvsl_pkg::CHG_DOWN;
    end else begin
      st_nxt.level       = st.level;
      st_nxt.last_change = st.last_change;
      res.change         = wvsl_pkg::CHG_NONE;
    end

    res.level      = st_nxt.level;
    res.up_votes   = up_cnt[wvsl_pkg::VOTE_W-1:0];
    res.down_votes = down_cnt[wvsl_pkg::VOTE_W-1:0];
  end

endmodule

// File: hw/rtl/window_vote_stepped_level.sv
// top level of the windowed vote stepped level block
// depends on wvsl_pkg, wvsl_step and assert_macros.svh
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready   in_tdata: up_sample, down_sample, now_ms
//  out_     out  out_tvalid/out_tready out_tdata: level, change, up_votes, down_votes
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// input stage, then result register; one word per cycle sustained while out_tready stays high
// the state update is a loop from st_r through wvsl_step back into st_r
// synchronous active-low reset clears windows, change time, valid flags; level and config get reset values
// a stalled output holds the input stage; in_tready drops only when both are full and out_tready is low
// cfg_ready is always high
`include "assert_macros.svh"

module window_vote_stepped_level (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] up_sample, [1] down_sample, [33:2] now_ms, [39:34] zero
  input  logic [wvsl_pkg::IN_W-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] level, [11:10] change, [15:12] up_votes, [19:16] down_votes, [23:20] zero
  output logic [wvsl_pkg::OUT_W-1:0]        out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wvsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wvsl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                        s1_valid_r;
  logic                        s1_up_r;
  logic                        s1_down_r;
  logic [wvsl_pkg::TIME_W-1:0] s1_now_r;
  logic                        out_valid_r;
  wvsl_pkg::res_t              out_res_r;
  wvsl_pkg::state_t            st_r;
  wvsl_pkg::state_t            st_nxt;
  wvsl_pkg::res_t              res;
  wvsl_pkg::cfg_t              cfg_r;
  logic                        advance;
  logic                        in_fire;

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(wvsl_pkg::OUT_W - $bits(wvsl_pkg::res_t)){1'b0}}, out_res_r};
  assign cfg_ready  = 1'b1;

  wvsl_step u_step (
    .cfg         (cfg_r),
    .st          (st_r),
    .up_sample   (s1_up_r),
    .down_sample (s1_down_r),
    .now_ms      (s1_now_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_fire) begin
      s1_up_r   <= in_tdata[0];
      s1_down_r <= in_tdata[1];
      s1_now_r  <= in_tdata[wvsl_pkg::TIME_W+1:2];
    end
  end

  // state and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r       <= 1'b0;
      st_r.up_win       <= '0;
      st_r.down_win     <= '0;
      st_r.last_change  <= '0;
      st_r.level        <= wvsl_pkg::LEVEL_RESET;
    end else begin
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vote_threshold <= wvsl_pkg::THRESHOLD_RESET;
      cfg_r.holdoff_ms     <= wvsl_pkg::HOLDOFF_RESET;
      cfg_r.upper_cap      <= wvsl_pkg::UPPER_CAP_RESET;
      cfg_r.lower_cap      <= wvsl_pkg::LOWER_CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wvsl_pkg::REG_VOTE_THRESHOLD:
          cfg_r.vote_threshold <= cfg_data[wvsl_pkg::VOTE_W-1:0];
        wvsl_pkg::REG_HOLDOFF_MS:
          cfg_r.holdoff_ms <= cfg_data[wvsl_pkg::HOLD_W-1:0];
        wvsl_pkg::REG_UPPER_CAP:
          cfg_r.upper_cap <= cfg_data[wvsl_pkg::CAP_W-1:0];
        wvsl_pkg::REG_LOWER_CAP:
          cfg_r.lower_cap <= cfg_data[wvsl_pkg::CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  `CHECK_IMPL(a_stall_blocks_input, s1_valid_r && out_valid_r && !out_tready, !in_tready, "input taken while both stages full")
  `CHECK_NEXT(a_level_hold, advance && res.change == wvsl_pkg::CHG_NONE, $stable(st_r.level), "level moved without a change")
  `CHECK_NEXT(a_change_time, advance && res.change != wvsl_pkg::CHG_NONE, st_r.last_change == $past(s1_now_r), "change time not recorded")
  `CHECK_IMPL(a_level_range, 1'b1, st_r.level >= wvsl_pkg::LEVEL_MIN && st_r.level <= wvsl_pkg::LEVEL_MAX, "level out of range")

endmodule

// File: dv/wvsl_checker.sv
// result checker for window_vote_stepped_level: tracks config writes and input words,
// predicts the gauge result of each word and compares it with the result words
// depends on wvsl_pkg
`timescale 1ns / 1ps

module wvsl_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [0] up_sample, [1] down_sample, [33:2] now_ms, [39:34] zero
  input  logic [wvsl_pkg::IN_W-1:0]       in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [9:0] level, [11:10] change, [15:12] up_votes, [19:16] down_votes, [23:20] zero
  input  logic [wvsl_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [wvsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wvsl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_cnt,
  output int                              pending,
  output int                              checked,
  output int                              ups,
  output int                              downs
);

  logic [wvsl_pkg::VOTE_W-1:0]         thr;
  logic [wvsl_pkg::HOLD_W-1:0]         hold;
  logic [wvsl_pkg::CAP_W-1:0]          ucap;
  logic [wvsl_pkg::CAP_W-1:0]          lcap;

  logic [wvsl_pkg::WINDOW-1:0]         up_hist;
  logic [wvsl_pkg::WINDOW-1:0]         dn_hist;
  logic [wvsl_pkg::TIME_W-1:0]         last_t;
  logic signed [wvsl_pkg::LEVEL_W-1:0] lvl;

  wvsl_pkg::res_t gauge_results_q[$];
  int   n_in = 0;
  int   n_out = 0;

  assign pending = n_in - n_out;
  assign checked = n_out;

  always @(posedge clk) begin : watch
    wvsl_pkg::res_t              want;
    wvsl_pkg::res_t              got;
    logic [wvsl_pkg::TIME_W-1:0] t;
    logic [wvsl_pkg::TIME_W-1:0] gap_t;
    logic [wvsl_pkg::VOTE_W-1:0] uv;
    logic [wvsl_pkg::VOTE_W-1:0] dv;
    logic                        hold_ok;
    wvsl_pkg::chg_t              chg;
    if (!rst_n) begin
      thr = wvsl_pkg::THRESHOLD_RESET;
      hold = wvsl_pkg::HOLDOFF_RESET;
      ucap = wvsl_pkg::UPPER_CAP_RESET;
      lcap = wvsl_pkg::LOWER_CAP_RESET;
      up_hist = '0;
      dn_hist = '0;
      last_t = '0;
      lvl = wvsl_pkg::LEVEL_RESET;
      gauge_results_q.delete();
      n_in <= 0;
      n_out <= 0;
      fail_cnt <= 0;
      ups <= 0;
      downs <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wvsl_pkg::REG_VOTE_THRESHOLD: thr = cfg_data[wvsl_pkg::VOTE_W-1:0];
          wvsl_pkg::REG_HOLDOFF_MS:     hold = cfg_data[wvsl_pkg::HOLD_W-1:0];
          wvsl_pkg::REG_UPPER_CAP:      ucap = cfg_data[wvsl_pkg::CAP_W-1:0];
          wvsl_pkg::REG_LOWER_CAP:      lcap = cfg_data[wvsl_pkg::CAP_W-1:0];
          default: ;
        endcase
      end

      // pop before push: a result never belongs to a word accepted at the same edge
      if (out_tvalid && out_tready) begin
        n_out <= n_out + 1;
        got = wvsl_pkg::res_t'(out_tdata[$bits(wvsl_pkg::res_t)-1:0]);
        if (gauge_results_q.size() == 0) begin
          fail_cnt <= fail_cnt + 1;
          if (fail_cnt < 10)
            $display("%0t: unexpected result word: level %0d change %0d up %0d down %0d",
                     $realtime, got.level, got.change, got.up_votes, got.down_votes);
        end else begin
          want = gauge_results_q.pop_front();
          if (got.level !== want.level || got.change !== want.change ||
              got.up_votes !== want.up_votes || got.down_votes !== want.down_votes) begin
            fail_cnt <= fail_cnt + 1;
            if (fail_cnt < 10)
              $display({"%0t: mismatch exp/act level %0d/%0d change %0d/%0d ",
                        "up %0d/%0d down %0d/%0d"},
                       $realtime, want.level, got.level, want.change, got.change,
                       want.up_votes, got.up_votes, want.down_votes, got.down_votes);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        n_in <= n_in + 1;
        up_hist = {up_hist[wvsl_pkg::WINDOW-2:0], in_tdata[0]};
        dn_hist = {dn_hist[wvsl_pkg::WINDOW-2:0], in_tdata[1]};
        t = in_tdata[wvsl_pkg::TIME_W+1:2];
        uv = wvsl_pkg::VOTE_W'($countones(up_hist));
        dv = wvsl_pkg::VOTE_W'($countones(dn_hist));
        gap_t = t - last_t;
        hold_ok = gap_t > wvsl_pkg::TIME_W'(hold);
        chg = wvsl_pkg::CHG_NONE;
        if (uv >= thr && hold_ok && int'(lvl) < int'(ucap)) begin
          lvl = lvl + wvsl_pkg::STEP_SIZE;
          last_t = t;
          chg = wvsl_pkg::CHG_UP;
          ups <= ups + 1;
        end else if (dv >= thr && hold_ok && int'(lvl) > int'(lcap)) begin
          lvl = lvl - wvsl_pkg::STEP_SIZE;
          last_t = t;
          chg = wvsl_pkg::CHG_DOWN;
          downs <= downs + 1;
        end
        want.level = lvl;
        want.change = chg;
        want.up_votes = uv;
        want.down_votes = dv;
        gauge_results_q.push_back(want);
      end
    end
  end

endmodule

// File: dv/window_vote_stepped_level_tb.sv
// testbench top for window_vote_stepped_level: directed and random input words,
// config phases and idling modes; results are checked by wvsl_checker
// depends on wvsl_pkg, wvsl_checker and the rtl
`timescale 1ns / 1ps

module window_vote_stepped_level_tb;

  localparam int LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_CYCLES = 300;
  localparam logic [wvsl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd9;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [wvsl_pkg::IN_W-1:0]       in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [wvsl_pkg::OUT_W-1:0]      out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [wvsl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wvsl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_cnt;
  int pending;
  int checked;
  int ups;
  int downs;

  int gap_pct = 0;
  int stall_pct = 0;
  int n_sent = 0;
  int n_cfg = 0;
  int n_phase = 0;
  int cycles = 0;
  int hold_left = 0;
  logic hold_tgl = 1'b0;
  logic hold_seen = 1'b0;

  always #5 clk = ~clk;

  window_vote_stepped_level uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wvsl_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_cnt   (fail_cnt),
    .pending    (pending),
    .checked    (checked),
    .ups        (ups),
    .downs      (downs)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input logic u, input logic d,
                           input logic [wvsl_pkg::TIME_W-1:0] t);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(wvsl_pkg::IN_W-wvsl_pkg::TIME_W-2){1'b0}}, t, d, u};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic settle;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [wvsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wvsl_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
  endtask

  task automatic apply_cfg(input logic [wvsl_pkg::CFG_DATA_W-1:0] thr,
                           input logic [wvsl_pkg::CFG_DATA_W-1:0] hold,
                           input logic [wvsl_pkg::CFG_DATA_W-1:0] ucap,
                           input logic [wvsl_pkg::CFG_DATA_W-1:0] lcap);
    settle();
    write_reg(wvsl_pkg::REG_VOTE_THRESHOLD, thr);
    write_reg(wvsl_pkg::REG_HOLDOFF_MS, hold);
    write_reg(wvsl_pkg::REG_UPPER_CAP, ucap);
    write_reg(wvsl_pkg::REG_LOWER_CAP, lcap);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input int m);
    case (m)
      0: begin gap_pct = 0;  stall_pct <= 0;  end
      1: begin gap_pct = 56; stall_pct <= 0;  end
      2: begin gap_pct = 0;  stall_pct <= 56; end
      default: begin gap_pct = 14; stall_pct <= 14; end
    endcase
  endtask

  initial begin
    logic [wvsl_pkg::TIME_W-1:0] tnow;
    logic [wvsl_pkg::TIME_W-1:0] t;
    int                          thr_v;
    int                          hold_v;
    int                          ucap_v;
    int                          lcap_v;
    int                          step_max;
    int                          pu;
    int                          pd;
    int                          k;
    logic                        u;
    logic                        d;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: both lines active, up wins once the votes reach the threshold
    for (int i = 1; i <= 7; i++) send_item(1'b1, 1'b1, wvsl_pkg::TIME_W'(i * 400));

    // threshold zero, no holdoff: equal time blocks, then up until the cap, then down
    apply_cfg(16'd0, 16'd0, 16'd255, 16'd0);
    send_item(1'b0, 1'b0, 32'd2400);
    for (int i = 1; i <= 6; i++) send_item(1'b0, 1'b0, wvsl_pkg::TIME_W'(2400 + i));

    // threshold above the window never passes; data bits past the width and
    // a write past the register list have no effect
    settle();
    write_reg(wvsl_pkg::REG_VOTE_THRESHOLD, 16'hFFFC);
    write_reg(wvsl_pkg::REG_HOLDOFF_MS, 16'd0);
    write_reg(wvsl_pkg::REG_UPPER_CAP, 16'd0);
    write_reg(wvsl_pkg::REG_LOWER_CAP, 16'd255);
    write_reg(wvsl_pkg::REG_UPPER_CAP, 16'hFF80);
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_item(1'b1, 1'b1, 32'd3000);
    send_item(1'b1, 1'b1, 32'd3001);

    // full window, longest holdoff, time wrapping past zero
    apply_cfg(16'd10, 16'hFFFF, 16'd255, 16'd0);
    for (int i = 0; i < 10; i++)
      send_item(1'b1, 1'b0, 32'hFFFF_FFF0 + wvsl_pkg::TIME_W'(i));
    send_item(1'b1, 1'b0, 32'h0000_FFF8);
    send_item(1'b1, 1'b0, 32'h0000_FFF9);
    send_item(1'b0, 1'b1, 32'hFFFF_FFFF);
    send_item(1'b0, 1'b0, 32'h0000_0000);

    tnow = 32'h0002_0000;
    pu = 50;
    pd = 50;
    while (n_sent < RANDOM_ITEMS + 27) begin
      thr_v = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 10 : 0)
                                          : $urandom_range(3, 8);
      case ($urandom_range(0, 9))
        0: hold_v = 0;
        1: hold_v = 65535;
        2: hold_v = $urandom_range(0, 65535);
        default: hold_v = $urandom_range(1, 60);
      endcase
      case ($urandom_range(0, 9))
        0: ucap_v = 255;
        1: ucap_v = 0;
        2: ucap_v = $urandom_range(0, 255);
        default: ucap_v = $urandom_range(150, 254);
      endcase
      case ($urandom_range(0, 9))
        0: lcap_v = 0;
        1: lcap_v = 255;
        2: lcap_v = $urandom_range(0, 255);
        default: lcap_v = $urandom_range(0, 110);
      endcase
      apply_cfg(wvsl_pkg::CFG_DATA_W'(thr_v), wvsl_pkg::CFG_DATA_W'(hold_v),
                wvsl_pkg::CFG_DATA_W'(ucap_v), wvsl_pkg::CFG_DATA_W'(lcap_v));
      set_mode(n_phase % 4);
      if (n_phase == 0) hold_tgl <= ~hold_tgl;
      step_max = hold_v / 4 + 3;
      for (k = 0; k < 60; k++) begin
        if (k % 12 == 0) begin
          case ($urandom_range(0, 3))
            0: begin pu = 90; pd = 10; end
            1: begin pu = 10; pd = 90; end
            2: begin pu = 85; pd = 85; end
            default: begin pu = 50; pd = 50; end
          endcase
        end
        u = ($urandom_range(0, 99) < pu);
        d = ($urandom_range(0, 99) < pd);
        if ($urandom_range(0, 19) == 0) begin
          t = $urandom;
        end else begin
          tnow = tnow + wvsl_pkg::TIME_W'($urandom_range(0, step_max));
          t = tnow;
        end
        send_item(u, d, t);
      end
      n_phase++;
    end

    settle();
    $display("%0d input words over %0d config phases, %0d config writes, %0d results checked",
             n_sent, n_phase + 4, n_cfg, checked);
    $display("level stepped up %0d times and down %0d times", ups, downs);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
